// ===== rtl/llf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llf_pkg
// Types and constants shared by the log level line filter.
// ----------------------------------------------------------------------------
package llf_pkg;

    localparam int BYTE_W    = 8;
    localparam int LEVEL_W   = 3;
    localparam int CONSOLE_W = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 4;
    localparam int HELD_W    = 2;
    localparam int MAX_OUT   = 3;
    localparam int OCNT_W    = 2;

    localparam logic [BYTE_W-1:0] CH_LT = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_GT = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_D0 = 8'h30;
    localparam logic [BYTE_W-1:0] CH_D7 = 8'h37;
    localparam logic [BYTE_W-1:0] CH_NL = 8'h0A;

    localparam logic [CFG_IDX_W-1:0] REG_CONSOLE_LEVEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_LEVEL = 2'd1;

    localparam logic [CONSOLE_W-1:0] CONSOLE_RESET = 4'd7;
    localparam logic [LEVEL_W-1:0]   DEFAULT_RESET = 3'd4;

    // tag recognizer codes
    localparam logic [HELD_W-1:0] HELD_NONE  = 2'd0;
    localparam logic [HELD_W-1:0] HELD_LT    = 2'd1;
    localparam logic [HELD_W-1:0] HELD_DIGIT = 2'd2;
    localparam logic [HELD_W-1:0] HELD_BAD   = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              chunk_end;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_run;
    } t_out_item;

endpackage

`default_nettype wire

// ===== rtl/log_level_line_filter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// log_level_line_filter_core
// Strips '<d>' level tags from line starts and passes lines below the
// console threshold, one text byte per transfer on each side.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while its output buffer can accept it. Each accepted
// byte lands in an input register, is decoded against the line state and
// loaded as a group of zero to three result bytes into a small output buffer,
// which drains one byte per cycle while the receiver is ready. The next byte
// is decoded as the last buffered byte leaves, so ordinary text streams at one
// byte per cycle; held bytes released by a broken tag hold the input while
// they drain through the single output port. Configuration writes are always accepted and should be made while idle.
module log_level_line_filter_core
    import llf_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output t_out_item            o_out_data,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [CFG_DAT_W-1:0]  i_cfg_data
);

    logic [CONSOLE_W-1:0] r_console;
    logic [LEVEL_W-1:0]   r_default;

    logic                 r_in_valid;
    t_in_item             r_in;

    logic                 r_line_start;
    logic [HELD_W-1:0]    r_held;
    logic [BYTE_W-1:0]    r_digit;
    logic [LEVEL_W-1:0]   r_level;
    logic                 r_passes;

    logic [BYTE_W-1:0]    r_ob [MAX_OUT];
    logic [OCNT_W-1:0]    r_ocnt;
    logic [OCNT_W-1:0]    r_optr;

    logic                 n_line_start;
    logic [HELD_W-1:0]    n_held;
    logic [BYTE_W-1:0]    n_digit;
    logic [LEVEL_W-1:0]   n_level;
    logic                 n_passes;
    logic [BYTE_W-1:0]    n_ob [MAX_OUT];
    logic [OCNT_W-1:0]    n_cnt;

    logic                 process;
    logic                 out_xfer;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = (r_ocnt != '0);
    assign out_xfer    = o_out_valid && i_out_ready;
    // buffer is free, or its last byte leaves this cycle
    assign process     = r_in_valid &&
                         ((r_ocnt == '0) || ((r_ocnt == OCNT_W'(1)) && i_out_ready));
    assign o_in_ready  = !r_in_valid || process;

    assign o_out_data.out_byte    = r_ob[r_optr];
    assign o_out_data.last_of_run = (r_ocnt == OCNT_W'(1));

    // decode of one byte against the line state
    always_comb begin
        logic [BYTE_W-1:0] b;
        logic              untag;
        logic              release_h;
        logic              take;
        b            = r_in.text_byte;
        untag        = 1'b0;
        release_h    = 1'b0;
        take         = 1'b0;
        n_line_start = r_line_start;
        n_held       = (r_held == HELD_BAD) ? HELD_NONE : r_held;
        n_digit      = r_digit;
        n_level      = r_level;
        n_passes     = r_passes;
        n_cnt        = '0;
        for (int k = 0; k < MAX_OUT; k++) begin
            n_ob[k] = '0;
        end

        if (!r_line_start) begin
            take = 1'b1;
        end else begin
            case (n_held)
                HELD_NONE: begin
                    if (b == CH_LT) begin
                        n_held = HELD_LT;
                    end else begin
                        untag = 1'b1;
                        take  = 1'b1;
                    end
                end
                HELD_LT: begin
                    if (b >= CH_D0 && b <= CH_D7) begin
                        n_digit = b;
                        n_held  = HELD_DIGIT;
                    end else begin
                        untag     = 1'b1;
                        release_h = 1'b1;
                        take      = 1'b1;
                    end
                end
                HELD_DIGIT: begin
                    if (b == CH_GT) begin
                        // digits '0'..'7' carry the level in their low bits
                        n_level      = r_digit[LEVEL_W-1:0];
                        n_passes     = ({1'b0, r_digit[LEVEL_W-1:0]} < r_console);
                        n_line_start = 1'b0;
                        n_held       = HELD_NONE;
                    end else begin
                        untag     = 1'b1;
                        release_h = 1'b1;
                        take      = 1'b1;
                    end
                end
                default: begin
                    n_held = HELD_NONE;
                end
            endcase
        end

        // chunk end flushes a held prefix as untagged text
        if (r_in.chunk_end && !untag && n_held != HELD_NONE) begin
            untag     = 1'b1;
            release_h = 1'b1;
        end

        if (untag) begin
            n_level      = r_default;
            n_passes     = ({1'b0, r_default} < r_console);
            n_line_start = 1'b0;
        end

        if (release_h) begin
            if (n_passes) begin
                n_ob[0] = CH_LT;
                n_cnt   = OCNT_W'(1);
                if (n_held == HELD_DIGIT) begin
                    n_ob[1] = n_digit;
                    n_cnt   = OCNT_W'(2);
                end
            end
            n_held = HELD_NONE;
        end

        if (take) begin
            if (n_passes) begin
                n_ob[n_cnt] = b;
                n_cnt       = n_cnt + OCNT_W'(1);
            end
            if (b == CH_NL) begin
                n_line_start = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_console    <= CONSOLE_RESET;
            r_default    <= DEFAULT_RESET;
            r_in_valid   <= 1'b0;
            r_line_start <= 1'b1;
            r_held       <= HELD_NONE;
            r_digit      <= '0;
            r_level      <= '0;
            r_passes     <= 1'b0;
            r_ocnt       <= '0;
            r_optr       <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_CONSOLE_LEVEL: r_console <= i_cfg_data;
                    REG_DEFAULT_LEVEL: r_default <= i_cfg_data[LEVEL_W-1:0];
                    default: ;
                endcase
            end

            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end

            if (process) begin
                r_line_start <= n_line_start;
                r_held       <= n_held;
                r_digit      <= n_digit;
                r_level      <= n_level;
                r_passes     <= n_passes;
                r_ocnt       <= n_cnt;
                r_optr       <= '0;
            end else if (out_xfer) begin
                r_ocnt <= r_ocnt - OCNT_W'(1);
                r_optr <= r_optr + OCNT_W'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (process) begin
            for (int k = 0; k < MAX_OUT; k++) begin
                r_ob[k] <= n_ob[k];
            end
        end
    end

endmodule

`default_nettype wire
